// ===== rtl/sfd_pkg.sv =====
`default_nettype none
package sfd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DELAY_W = 16;
  localparam int FEEDBACK_W = 8;
  localparam int WET_W = 9;
  // effect before saturation: old dry plus scaled feedback
  localparam int EFFECT_W = 18;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 5;

  localparam int DEFAULT_HISTORY_FRAMES = 65536;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;

  // cycles that the read offsets need to settle after a delay change
  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  typedef enum logic [2:0] {
    REG_DELAY_LEFT,
    REG_DELAY_RIGHT,
    REG_FEEDBACK_GAIN,
    REG_WET_GAIN,
    REG_CROSSED_MODE,
    REG_INVERT_EFFECT,
    REG_INVERT_FEEDBACK
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB_LEFT,
    ST_FB_RIGHT,
    ST_MIX_LEFT,
    ST_MIX_RIGHT
  } ctrl_state_t;

  typedef struct packed {
    logic [DELAY_W-1:0]    delay_left;
    logic [DELAY_W-1:0]    delay_right;
    logic [FEEDBACK_W-1:0] feedback;
    logic [WET_W-1:0]      wet;
    logic                  crossed;
    logic                  invert_effect;
    logic                  invert_feedback;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic effect_left;
    logic effect_right;
    logic result_left;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [23:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/stereo_feedback_delay.sv =====
`default_nettype none
// Stereo echo with feedback. One stereo frame goes in on the slave stream and one
// mixed frame comes out on the master stream. The four history memories are read at
// the acceptance edge itself. Then ST_FB_LEFT and ST_FB_RIGHT form the left and then
// the right effect in the shared feedback multiplier, and ST_FB_RIGHT also forms the
// left mix products; ST_MIX_LEFT clips the left mix and forms the right products;
// ST_MIX_RIGHT clips the right mix and loads the output register. The next frame is
// taken only once the controller is back in its idle state, so one frame is in work
// at a time. The result waits in an output register, so a frame can be accepted and
// worked on while the previous result is not yet taken; ST_MIX_RIGHT is held until
// that result goes. After reset and after any register write the input is held off
// while the read offsets (delay modulo history length) are recomputed. History entries
// read as zero until written; a fill count tracks this, so no clearing pass runs.
module stereo_feedback_delay
  import sfd_pkg::*;
#(
  parameter int HISTORY_FRAMES = DEFAULT_HISTORY_FRAMES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [DATA_W-1:0]  s_axis_tdata,   // [15:0] left_in, [31:16] right_in
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [DATA_W-1:0]  m_axis_tdata,   // [15:0] left_out, [31:16] right_out
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_write;
  reg_index_t reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_index_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_left      <= DELAY_RESET;
      cfg.delay_right     <= DELAY_RESET;
      cfg.feedback        <= '0;
      cfg.wet             <= '0;
      cfg.crossed         <= 1'b0;
      cfg.invert_effect   <= 1'b0;
      cfg.invert_feedback <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_DELAY_LEFT:      cfg.delay_left      <= pwdata[DELAY_W-1:0];
        REG_DELAY_RIGHT:     cfg.delay_right     <= pwdata[DELAY_W-1:0];
        REG_FEEDBACK_GAIN:   cfg.feedback        <= pwdata[FEEDBACK_W-1:0];
        REG_WET_GAIN:        cfg.wet             <= pwdata[WET_W-1:0];
        REG_CROSSED_MODE:    cfg.crossed         <= pwdata[0];
        REG_INVERT_EFFECT:   cfg.invert_effect   <= pwdata[0];
        REG_INVERT_FEEDBACK: cfg.invert_feedback <= pwdata[0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_DELAY_LEFT:      prdata = DATA_W'(cfg.delay_left);
      REG_DELAY_RIGHT:     prdata = DATA_W'(cfg.delay_right);
      REG_FEEDBACK_GAIN:   prdata = DATA_W'(cfg.feedback);
      REG_WET_GAIN:        prdata = DATA_W'(cfg.wet);
      REG_CROSSED_MODE:    prdata = DATA_W'(cfg.crossed);
      REG_INVERT_EFFECT:   prdata = DATA_W'(cfg.invert_effect);
      REG_INVERT_FEEDBACK: prdata = DATA_W'(cfg.invert_feedback);
      default:             prdata = '0;
    endcase
  end

  sfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .cfg_write (cfg_write),
    .status    (status),
    .cmd       (cmd)
  );

  sfd_datapath #(.HISTORY_FRAMES(HISTORY_FRAMES)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .in_tdata   (s_axis_tdata),
    .out_tdata  (m_axis_tdata),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .status     (status)
  );

endmodule
`default_nettype wire

// ===== rtl/sfd_ram.sv =====
`default_nettype none
module sfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sfd_ctrl.sv =====
`default_nettype none
module sfd_ctrl
  import sfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic       cfg_write,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  ctrl_state_t state, state_next;
  logic [1:0]  settle;

  // hold the input off while the datapath recomputes its read offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_CYCLES;
    end else if (cfg_write) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_tvalid && settle == 2'd0) begin
          state_next = ST_FB_LEFT;
        end
      end
      ST_FB_LEFT:  state_next = ST_FB_RIGHT;
      ST_FB_RIGHT: state_next = ST_MIX_LEFT;
      ST_MIX_LEFT: state_next = ST_MIX_RIGHT;
      ST_MIX_RIGHT: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_IDLE: begin
        in_tready  = (settle == 2'd0);
        cmd.accept = in_tvalid && (settle == 2'd0);
      end
      ST_FB_LEFT:   cmd.effect_left  = 1'b1;
      ST_FB_RIGHT:  cmd.effect_right = 1'b1;
      ST_MIX_LEFT:  cmd.result_left  = 1'b1;
      ST_MIX_RIGHT: cmd.finish       = !status.out_busy;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sfd_datapath.sv =====
`default_nettype none
module sfd_datapath
  import sfd_pkg::*;
#(
  parameter int HISTORY_FRAMES = DEFAULT_HISTORY_FRAMES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire ctrl_cmd_t         cmd,
  input  wire logic [DATA_W-1:0] in_tdata,
  output logic      [DATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output dp_status_t             status
);

  localparam int ADDR_W  = $clog2(HISTORY_FRAMES);
  localparam int CNT_W   = $clog2(HISTORY_FRAMES + 1);
  localparam int SHIFT   = DELAY_W + ADDR_W;
  localparam int RECIP_W = DELAY_W + 2;
  localparam int PROD_W  = DELAY_W + RECIP_W;
  localparam int QM_W    = DELAY_W + ADDR_W + 1;
  localparam logic [63:0]        RECIP_FULL = (64'd1 << SHIFT) / HISTORY_FRAMES;
  localparam logic [RECIP_W-1:0] RECIP      = RECIP_FULL[RECIP_W-1:0];
  localparam logic [QM_W-1:0]    HIST_QM    = QM_W'(HISTORY_FRAMES);
  localparam logic [ADDR_W:0]    HIST_A     = (ADDR_W + 1)'(HISTORY_FRAMES);
  localparam logic [CNT_W-1:0]   HIST_CNT   = CNT_W'(HISTORY_FRAMES);
  localparam logic [ADDR_W-1:0]  LAST_POS   = ADDR_W'(HISTORY_FRAMES - 1);

  // delay modulo history length: reciprocal estimate, then one correction
  logic [PROD_W-1:0] recip_prod_l, recip_prod_r;
  logic [QM_W-1:0]   quot_mult_l, quot_mult_r;
  logic [QM_W-1:0]   rem_l, rem_r;
  logic [ADDR_W-1:0] back_l, back_r, back_l_next, back_r_next;

  always_ff @(posedge clk) begin
    recip_prod_l <= PROD_W'(cfg.delay_left) * PROD_W'(RECIP);
    recip_prod_r <= PROD_W'(cfg.delay_right) * PROD_W'(RECIP);
    quot_mult_l  <= QM_W'(recip_prod_l >> SHIFT) * HIST_QM;
    quot_mult_r  <= QM_W'(recip_prod_r >> SHIFT) * HIST_QM;
    back_l       <= back_l_next;
    back_r       <= back_r_next;
  end

  always_comb begin
    rem_l       = QM_W'(cfg.delay_left) - quot_mult_l;
    rem_r       = QM_W'(cfg.delay_right) - quot_mult_r;
    back_l_next = (rem_l >= HIST_QM) ? ADDR_W'(rem_l - HIST_QM) : ADDR_W'(rem_l);
    back_r_next = (rem_r >= HIST_QM) ? ADDR_W'(rem_r - HIST_QM) : ADDR_W'(rem_r);
  end

  // frame position and count of frames written so far
  logic [ADDR_W-1:0] pos;
  logic [CNT_W-1:0]  fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      fill <= '0;
    end else if (cmd.finish) begin
      pos <= (pos == LAST_POS) ? '0 : pos + ADDR_W'(1);
      if (fill != HIST_CNT) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  logic [ADDR_W:0]   diff_l, diff_r;
  logic [ADDR_W-1:0] rd_l, rd_r, lmem_raddr, rmem_raddr;

  always_comb begin
    diff_l     = {1'b0, pos} - {1'b0, back_l};
    diff_r     = {1'b0, pos} - {1'b0, back_r};
    rd_l       = diff_l[ADDR_W] ? ADDR_W'(diff_l + HIST_A) : diff_l[ADDR_W-1:0];
    rd_r       = diff_r[ADDR_W] ? ADDR_W'(diff_r + HIST_A) : diff_r[ADDR_W-1:0];
    lmem_raddr = cfg.crossed ? rd_r : rd_l;
    rmem_raddr = cfg.crossed ? rd_l : rd_r;
  end

  logic signed [SAMPLE_W-1:0] smp_l, smp_r;
  logic                       valid_l, valid_r, fwd_l, fwd_r;

  // never-written entries read as zero; a zero offset reads this frame's dry sample
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_l   <= in_tdata[SAMPLE_W-1:0];
      smp_r   <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
      valid_l <= CNT_W'(rd_l) < fill;
      valid_r <= CNT_W'(rd_r) < fill;
      fwd_l   <= (back_l == '0);
      fwd_r   <= (back_r == '0);
    end
  end

  logic [SAMPLE_W-1:0]         dry_left_q, dry_right_q, eff_left_q, eff_right_q;
  logic signed [EFFECT_W-1:0]  effect_l, effect_r;
  logic signed [SAMPLE_W-1:0]  res_left, mix_res;

  sfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(HISTORY_FRAMES)) u_dry_left (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (pos),
    .wdata (smp_l),
    .re    (cmd.accept),
    .raddr (lmem_raddr),
    .rdata (dry_left_q)
  );

  sfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(HISTORY_FRAMES)) u_dry_right (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (pos),
    .wdata (smp_r),
    .re    (cmd.accept),
    .raddr (rmem_raddr),
    .rdata (dry_right_q)
  );

  sfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(HISTORY_FRAMES)) u_eff_left (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (pos),
    .wdata (sat_sample(24'(effect_l))),
    .re    (cmd.accept),
    .raddr (lmem_raddr),
    .rdata (eff_left_q)
  );

  sfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(HISTORY_FRAMES)) u_eff_right (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (pos),
    .wdata (sat_sample(24'(effect_r))),
    .re    (cmd.accept),
    .raddr (rmem_raddr),
    .rdata (eff_right_q)
  );

  logic signed [SAMPLE_W-1:0] src_dry_l, src_dry_r, src_eff_l, src_eff_r;
  logic signed [SAMPLE_W-1:0] old_dry_l, old_dry_r, old_eff_l, old_eff_r;

  always_comb begin
    src_dry_l = cfg.crossed ? dry_right_q : dry_left_q;
    src_eff_l = cfg.crossed ? eff_right_q : eff_left_q;
    src_dry_r = cfg.crossed ? dry_left_q : dry_right_q;
    src_eff_r = cfg.crossed ? eff_left_q : eff_right_q;
    if (fwd_l) begin
      old_dry_l = cfg.crossed ? smp_r : smp_l;
    end else begin
      old_dry_l = valid_l ? src_dry_l : '0;
    end
    if (fwd_r) begin
      old_dry_r = cfg.crossed ? smp_l : smp_r;
    end else begin
      old_dry_r = valid_r ? src_dry_r : '0;
    end
    old_eff_l = valid_l ? src_eff_l : '0;
    // crossed with zero offset: the right side sees the left effect stored this frame
    if (cfg.crossed && fwd_r) begin
      old_eff_r = sat_sample(24'(effect_l));
    end else begin
      old_eff_r = valid_r ? src_eff_r : '0;
    end
  end

  // shared feedback unit
  logic signed [SAMPLE_W-1:0]  fb_dry, fb_old;
  logic signed [SAMPLE_W:0]    fb_eff;
  logic signed [FEEDBACK_W:0]  fb_gain;
  logic signed [25:0]          fb_prod;
  logic signed [EFFECT_W-1:0]  fb_sum, effect_next;

  always_comb begin
    fb_dry      = cmd.effect_right ? old_dry_r : old_dry_l;
    fb_old      = cmd.effect_right ? old_eff_r : old_eff_l;
    fb_eff      = cfg.invert_feedback ? -(SAMPLE_W + 1)'(fb_old) : (SAMPLE_W + 1)'(fb_old);
    fb_gain     = $signed({1'b0, cfg.feedback});
    fb_prod     = fb_eff * fb_gain;
    fb_sum      = EFFECT_W'(fb_prod >>> 8) + EFFECT_W'(fb_dry);
    effect_next = cfg.invert_effect ? -fb_sum : fb_sum;
  end

  always_ff @(posedge clk) begin
    if (cmd.effect_left) begin
      effect_l <= effect_next;
    end
    if (cmd.effect_right) begin
      effect_r <= effect_next;
    end
  end

  // shared mix unit: products are registered, then summed and clipped
  logic signed [SAMPLE_W-1:0] mix_smp;
  logic signed [EFFECT_W-1:0] mix_eff;
  logic signed [WET_W:0]      dry_weight, wet_weight;
  logic signed [25:0]         prod_dry, prod_dry_next;
  logic signed [27:0]         prod_wet, prod_wet_next;
  logic signed [28:0]         mix_sum;

  always_comb begin
    mix_smp       = cmd.result_left ? smp_r : smp_l;
    mix_eff       = cmd.result_left ? effect_r : effect_l;
    wet_weight    = $signed({1'b0, cfg.wet});
    dry_weight    = 10'sd256 - wet_weight;
    prod_dry_next = mix_smp * dry_weight;
    prod_wet_next = wet_weight * mix_eff;
    mix_sum       = prod_dry + prod_wet;
    mix_res       = sat_sample(24'(mix_sum >>> 8));
  end

  always_ff @(posedge clk) begin
    if (cmd.effect_right || cmd.result_left) begin
      prod_dry <= prod_dry_next;
      prod_wet <= prod_wet_next;
    end
    if (cmd.result_left) begin
      res_left <= mix_res;
    end
    if (cmd.finish) begin
      out_tdata <= {mix_res, res_left};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  assign status.out_busy = out_tvalid && !out_tready;

endmodule
`default_nettype wire

// ===== rtl/sfd_checker.sv =====
`default_nettype none
module sfd_checker
  import sfd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_axis_tvalid,
  input wire logic               s_axis_tready,
  input wire logic [DATA_W-1:0]  s_axis_tdata,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [DATA_W-1:0]  m_axis_tdata,
  input wire logic               psel,
  input wire logic               penable,
  input wire logic               pwrite,
  input wire logic [PADDR_W-1:0] paddr,
  input wire logic [DATA_W-1:0]  pwdata,
  input wire logic [DATA_W-1:0]  prdata,
  input wire logic               pready
);

  logic unused_ok;
  assign unused_ok = ^{s_axis_tdata, paddr, pwdata, prdata};

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one frame at a time: no second frame right behind the first
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("frame taken while another is in work");

  // input is held off while read offsets settle after a register write
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready |=> !s_axis_tready)
    else $error("frame taken before offsets settled");

endmodule

bind stereo_feedback_delay sfd_checker u_sfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);
`default_nettype wire

// ===== tb/tb_stereo_feedback_delay.sv =====
`timescale 1ns / 1ps
module tb_stereo_feedback_delay;
  import sfd_pkg::*;

  localparam int IDX_BEYOND_LAST = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL = 80;
  localparam int PHASES = 10;
  localparam int PHASE_FRAMES = 115;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
  } frame_t;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata;   // [15:0] left_in, [31:16] right_in
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [DATA_W-1:0]  m_axis_tdata;   // [15:0] left_out, [31:16] right_out
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  stereo_feedback_delay dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // echo state mirrored from the block
  bit signed [15:0] dry_hist_l [65536];
  bit signed [15:0] dry_hist_r [65536];
  bit signed [15:0] eff_hist_l [65536];
  bit signed [15:0] eff_hist_r [65536];
  logic [15:0]      wr_pos;
  cfg_t             cfg_now;

  frame_t mixed_due[$];
  int     mismatches;
  int     cycles;
  bit     calm;
  bit     stall_req;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch %s at cycle %0d: got %h, want %h", what, cycles, got, want);
  endtask

  function automatic logic signed [15:0] clip16(input longint v);
    if (v < -32768) return 16'sh8000;
    if (v > 32767) return 16'sh7fff;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] echo_channel(input logic signed [15:0] dry,
                                                      input logic [15:0] delay,
                                                      input bit from_right,
                                                      input bit to_right);
    logic [15:0] rd;
    longint dry_v, old_dry, old_eff, eff, fb, wet;
    rd = wr_pos - delay;
    dry_v = dry;
    old_dry = from_right ? dry_hist_r[rd] : dry_hist_l[rd];
    old_eff = from_right ? eff_hist_r[rd] : eff_hist_l[rd];
    fb = cfg_now.feedback;
    wet = cfg_now.wet;
    if (cfg_now.invert_feedback) old_eff = -old_eff;
    eff = old_dry + ((old_eff * fb) >>> 8);
    if (cfg_now.invert_effect) eff = -eff;
    if (to_right) eff_hist_r[wr_pos] = clip16(eff);
    else eff_hist_l[wr_pos] = clip16(eff);
    return clip16((dry_v * (256 - wet) + wet * eff) >>> 8);
  endfunction

  // left is worked out first: in crossed mode the right channel may read it back
  function automatic void mix_frame(input logic [15:0] l, input logic [15:0] r);
    frame_t f;
    dry_hist_l[wr_pos] = l;
    dry_hist_r[wr_pos] = r;
    if (cfg_now.crossed) begin
      f.left = echo_channel(l, cfg_now.delay_left, 1'b1, 1'b0);
      f.right = echo_channel(r, cfg_now.delay_right, 1'b0, 1'b1);
    end else begin
      f.left = echo_channel(l, cfg_now.delay_left, 1'b0, 1'b0);
      f.right = echo_channel(r, cfg_now.delay_right, 1'b1, 1'b1);
    end
    mixed_due.push_back(f);
    wr_pos = wr_pos + 16'd1;
  endfunction

  function automatic logic [31:0] reg_mask(input int idx);
    case (idx)
      REG_DELAY_LEFT, REG_DELAY_RIGHT: return 32'hffff;
      REG_FEEDBACK_GAIN: return 32'hff;
      REG_WET_GAIN: return 32'h1ff;
      REG_CROSSED_MODE, REG_INVERT_EFFECT, REG_INVERT_FEEDBACK: return 32'h1;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(input int idx);
    case (idx)
      REG_DELAY_LEFT: return 32'(cfg_now.delay_left);
      REG_DELAY_RIGHT: return 32'(cfg_now.delay_right);
      REG_FEEDBACK_GAIN: return 32'(cfg_now.feedback);
      REG_WET_GAIN: return 32'(cfg_now.wet);
      REG_CROSSED_MODE: return 32'(cfg_now.crossed);
      REG_INVERT_EFFECT: return 32'(cfg_now.invert_effect);
      REG_INVERT_FEEDBACK: return 32'(cfg_now.invert_feedback);
      default: return 32'h0;
    endcase
  endfunction

  always @(posedge clk) begin
    frame_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (mixed_due.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata, 32'h0);
      end else begin
        want = mixed_due.pop_front();
        if (m_axis_tdata[15:0] !== want.left)
          report_mismatch("left_out", 32'(m_axis_tdata[15:0]), 32'(want.left));
        if (m_axis_tdata[31:16] !== want.right)
          report_mismatch("right_out", 32'(m_axis_tdata[31:16]), 32'(want.right));
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_req) begin
        m_axis_tready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stall_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // called and returns at a falling edge; valid stays high for a following item
  task automatic send_frame(input logic [15:0] l, input logic [15:0] r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {r, l};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    mix_frame(l, r);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (mixed_due.size() != 0) @(negedge clk);
  endtask

  task automatic apb_write(input int idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = reg_mask(idx);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = PADDR_W'(idx * 4);
    pwdata = ($urandom & ~mask) | (value & mask);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_DELAY_LEFT: cfg_now.delay_left = pwdata[15:0];
      REG_DELAY_RIGHT: cfg_now.delay_right = pwdata[15:0];
      REG_FEEDBACK_GAIN: cfg_now.feedback = pwdata[7:0];
      REG_WET_GAIN: cfg_now.wet = pwdata[8:0];
      REG_CROSSED_MODE: cfg_now.crossed = pwdata[0];
      REG_INVERT_EFFECT: cfg_now.invert_effect = pwdata[0];
      REG_INVERT_FEEDBACK: cfg_now.invert_feedback = pwdata[0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_read_check(input int idx);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = PADDR_W'(idx * 4);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & reg_mask(idx)) !== reg_value(idx))
      report_mismatch("register read", prdata, reg_value(idx));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(input logic [15:0] dl, input logic [15:0] dr,
                           input logic [7:0] fb, input logic [8:0] wet,
                           input bit cr, input bit inv_eff, input bit inv_fb);
    drain();
    apb_write(REG_DELAY_LEFT, 32'(dl));
    apb_write(REG_DELAY_RIGHT, 32'(dr));
    apb_write(REG_FEEDBACK_GAIN, 32'(fb));
    apb_write(REG_WET_GAIN, 32'(wet));
    apb_write(REG_CROSSED_MODE, 32'(cr));
    apb_write(REG_INVERT_EFFECT, 32'(inv_eff));
    apb_write(REG_INVERT_FEEDBACK, 32'(inv_fb));
    for (int i = 0; i <= int'(REG_INVERT_FEEDBACK); i++) apb_read_check(i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly short echoes so the history is really read back
  function automatic logic [15:0] pick_delay();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd10;
      2: return 16'd65436;
      3: return 16'd65535;
      4: return 16'($urandom);
      default: return 16'($urandom_range(1, 150));
    endcase
  endfunction

  task automatic test_reset_values();
    for (int i = 0; i <= int'(REG_INVERT_FEEDBACK); i++) apb_read_check(i);
    send_frame(16'h7fff, 16'h8000);
    send_frame(16'h8000, 16'h7fff);
    send_frame(16'h0000, 16'hffff);
    send_frame(16'h0001, 16'h5555);
  endtask

  task automatic test_effect_saturation();
    configure(16'd1, 16'd2, 8'd255, 9'd256, 1'b0, 1'b0, 1'b0);
    repeat (3) send_frame(16'h7fff, 16'h8000);
    repeat (3) send_frame(16'h8000, 16'h7fff);
  endtask

  task automatic test_out_of_range();
    // delay of zero reads this frame's dry sample; wet above 256 makes dry weight negative
    configure(16'd0, 16'd65535, 8'd240, 9'd511, 1'b0, 1'b0, 1'b1);
    drain();
    apb_write(IDX_BEYOND_LAST, 32'($urandom));
    for (int i = 0; i <= int'(REG_INVERT_FEEDBACK); i++) apb_read_check(i);
    send_frame(16'h7fff, 16'h1234);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h4000, 16'hc000);
    send_frame(16'hffff, 16'h7fff);
    send_frame(16'h0000, 16'h0001);
  endtask

  task automatic test_crossed_inverted();
    configure(16'd1, 16'd0, 8'd200, 9'd128, 1'b1, 1'b1, 1'b1);
    send_frame(16'h7fff, 16'h8000);
    send_frame(16'h1000, 16'h2000);
    send_frame(16'h8000, 16'h7fff);
    send_frame(16'hfff0, 16'h0010);
    send_frame(16'h0000, 16'h0000);
    send_frame(16'h3333, 16'hcccc);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)
        configure(16'd0, 16'd0, 8'd0, 9'd0, 1'b0, 1'b0, 1'b0);
      else if (p == 1)
        configure(16'hffff, 16'hffff, 8'hff, 9'h1ff, 1'b1, 1'b1, 1'b1);
      else
        configure(pick_delay(), pick_delay(),
                  ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 230)),
                  ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 256)),
                  1'($urandom), 1'($urandom), 1'($urandom));
      repeat (PHASE_FRAMES) send_frame(rand_sample(), rand_sample());
    end
  endtask

  task automatic test_backpressure();
    configure(16'd3, 16'd7, 8'd128, 9'd200, 1'b0, 1'b0, 1'b0);
    calm = 1'b1;
    stall_req = 1'b1;
    repeat (30) send_frame(rand_sample(), rand_sample());
    calm = 1'b0;
  endtask

  task automatic test_steady_stream();
    configure(16'd20, 16'd33, 8'd180, 9'd160, 1'b1, 1'b0, 1'b1);
    calm = 1'b1;
    repeat (150) send_frame(rand_sample(), rand_sample());
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    mismatches = 0;
    calm = 1'b0;
    stall_req = 1'b0;
    wr_pos = '0;
    cfg_now = '0;
    cfg_now.delay_left = DELAY_RESET;
    cfg_now.delay_right = DELAY_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_effect_saturation();
    test_out_of_range();
    test_crossed_inverted();
    test_random_settings();
    test_backpressure();
    test_steady_stream();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== stereo_feedback_delay.f =====
rtl/sfd_pkg.sv
rtl/sfd_ram.sv
rtl/sfd_ctrl.sv
rtl/sfd_datapath.sv
rtl/stereo_feedback_delay.sv
rtl/sfd_checker.sv
tb/tb_stereo_feedback_delay.sv
